FILE: rtl/adpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adpf_pkg
// Shared sizes, table entry type and verdict codes of the duplicate filter.
// ----------------------------------------------------------------------------
package adpf_pkg;

  // Number of table entries, one per source.
  localparam int SOURCE_COUNT = 256;
  localparam int IDX_W        = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;

  // Field widths fixed by the interface.
  localparam int SRC_W     = 8;
  localparam int SEQ_W     = 32;
  localparam int AGE_W     = 16;
  localparam int VERDICT_W = 2;

  // Item kinds.
  localparam logic FUNC_PACKET = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_STALE    = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_UPSTREAM = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_TICK     = 2'd3;

  // One table word as stored in the memory.
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [AGE_W-1:0] age;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/aging_duplicate_packet_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aging_duplicate_packet_filter_core
// Per-source sequence number filter with tick-driven aging of its entries.
// ----------------------------------------------------------------------------
// The block handles one request at a time. A packet request has its source
// entry read from the table memory at the accepting edge, and the following
// cycle decides and writes the entry back; its result is then registered, or
// held while the output register is still occupied. A tick request sweeps
// the whole table through the memory's read and write ports, one entry per
// cycle with the write-back in the cycle after the read; no request is
// accepted meanwhile. Valid bits live in flip-flops and are cleared by reset,
// so no clearing pass is needed. The result sits in an output register, and a
// new request is accepted while it waits to be taken. The max_age register
// may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module aging_duplicate_packet_filter_core
  import adpf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write channel.
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [AGE_W-1:0]     cfg_max_age_i,
  // Input request channel.
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 func_i,
  input  wire logic [SRC_W-1:0]     source_id_i,
  input  wire logic [SEQ_W-1:0]     seq_num_i,
  input  wire logic                 upstream_drop_i,
  // Result channel.
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [VERDICT_W-1:0]      verdict_o
);

  // State codes.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PKT      = 3'd1;
  localparam logic [2:0] ST_TICK     = 3'd2;
  localparam logic [2:0] ST_TICK_END = 3'd3;
  localparam logic [2:0] ST_FIN      = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SOURCE_COUNT - 1);

  logic [2:0]              state_q, state_d;
  logic [AGE_W-1:0]        max_age_q, max_age_d;
  logic [SOURCE_COUNT-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]        wb_idx_q, wb_idx_d;
  logic                    wb_vld_q, wb_vld_d;
  logic                    out_valid_q, out_valid_d;
  logic [VERDICT_W-1:0]    verdict_q, verdict_d;
  logic [VERDICT_W-1:0]    pend_q, pend_d;

  // Latched packet fields.
  logic [SRC_W-1:0]        src_q;
  logic [SEQ_W-1:0]        seq_q;
  logic                    drop_q;

  // Table memory.
  entry_t                  mem [SOURCE_COUNT];
  entry_t                  rd_data_q;
  logic [IDX_W-1:0]        rd_addr;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  entry_t                  mem_wd;

  logic                    in_fire;
  logic                    src_in_range;
  logic [IDX_W-1:0]        src_idx;
  logic                    pkt_accept;
  logic                    result_vld;
  logic [VERDICT_W-1:0]    result_verdict;
  logic                    out_free;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign verdict_o    = verdict_q;
  assign out_free     = !out_valid_q || out_ready_i;

  // Source index and range check of the latched packet.
  assign src_idx      = src_q[IDX_W-1:0];
  assign src_in_range = ({1'b0, src_q} < (SRC_W + 1)'(SOURCE_COUNT));

  // Read address: the arriving source when idle, the sweep counter otherwise.
  assign rd_addr = (state_q == ST_IDLE) ? source_id_i[IDX_W-1:0] : cnt_q;

  // Packet decision, made in the cycle the entry read returns.
  assign pkt_accept = !drop_q && src_in_range &&
                      (!valid_q[src_idx] ||
                       ((rd_data_q.seq < seq_q) && (rd_data_q.age != '0)));

  // Memory write, valid bit update and the result of the current step.
  always_comb begin
    mem_we         = 1'b0;
    mem_wa         = src_idx;
    mem_wd         = '{seq: seq_q, age: max_age_q};
    valid_d        = valid_q;
    result_vld     = 1'b0;
    result_verdict = pend_q;

    unique case (state_q)
      ST_PKT: begin
        result_vld = 1'b1;
        if (drop_q) begin
          result_verdict = VERDICT_UPSTREAM;
        end else if (pkt_accept) begin
          result_verdict   = VERDICT_ACCEPT;
          mem_we           = 1'b1;
          valid_d[src_idx] = 1'b1;
        end else begin
          result_verdict = VERDICT_STALE;
        end
      end
      ST_TICK, ST_TICK_END: begin
        // Age the entry whose read came back this cycle.
        mem_wa = wb_idx_q;
        mem_wd = '{seq: rd_data_q.seq, age: rd_data_q.age - AGE_W'(1)};
        if (wb_vld_q && valid_q[wb_idx_q]) begin
          if (rd_data_q.age == '0) begin
            valid_d[wb_idx_q] = 1'b0;
          end else begin
            mem_we = 1'b1;
          end
        end
        if (state_q == ST_TICK_END) begin
          result_vld     = 1'b1;
          result_verdict = VERDICT_TICK;
        end
      end
      ST_FIN: begin
        result_vld = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register control.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wb_idx_d    = wb_idx_q;
    wb_vld_d    = wb_vld_q;
    pend_d      = pend_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && !out_ready_i;
    max_age_d   = cfg_valid_i ? cfg_max_age_i : max_age_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d    = '0;
          wb_vld_d = 1'b0;
          state_d  = (func_i == FUNC_TICK) ? ST_TICK : ST_PKT;
        end
      end
      ST_TICK: begin
        wb_vld_d = 1'b1;
        wb_idx_d = cnt_q;
        cnt_d    = cnt_q + IDX_W'(1);
        if (cnt_q == LAST_IDX) begin
          state_d = ST_TICK_END;
        end
      end
      default: begin
      end
    endcase

    // Hand the finished result to the output register, or hold it.
    if (result_vld) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        verdict_d   = result_verdict;
        state_d     = ST_IDLE;
      end else begin
        pend_d  = result_verdict;
        state_d = ST_FIN;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_age_q   <= AGE_W'(10);
      valid_q     <= '0;
      cnt_q       <= '0;
      wb_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      max_age_q   <= max_age_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      wb_vld_q    <= wb_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    wb_idx_q  <= wb_idx_d;
    pend_q    <= pend_d;
    verdict_q <= verdict_d;
    if (in_fire) begin
      src_q  <= source_id_i;
      seq_q  <= seq_num_i;
      drop_q <= upstream_drop_i;
    end
  end

  // Table memory with registered read.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the aging duplicate packet filter core.
// ----------------------------------------------------------------------------
// Packet and tick requests go in over a valid/ready channel, and the verdicts
// are taken back with random backpressure. A scoreboard keeps its own copy of
// the per-source table and predicts every verdict when its request is
// accepted. A directed opening covers the corner cases. Random traffic then
// follows, mostly rising sequence numbers on a few busy sources with
// duplicates, stale numbers, upstream drops and aging ticks mixed in. The
// max_age register is rewritten between phases, only while the core is idle.
// ----------------------------------------------------------------------------
module tb_top
  import adpf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd10;
  localparam int               HOT_COUNT     = 6;
  localparam int               SEG_COUNT     = 6;
  localparam int               SEG_ITEMS     = 230;
  // A tick sweep visits every table entry; leave room after the last one.
  localparam int               TAIL_CYCLES   = 300;
  localparam int unsigned      CYCLE_LIMIT   = 2_000_000;

  // Predicts one verdict per request from its own copy of the source table.
  class dup_filter_scoreboard;
    bit                   entry_live[SOURCE_COUNT];
    logic [SEQ_W-1:0]     entry_seq[SOURCE_COUNT];
    logic [AGE_W-1:0]     entry_age[SOURCE_COUNT];
    logic [AGE_W-1:0]     max_age;
    logic [VERDICT_W-1:0] expected_verdicts[$];
    int unsigned          error_count;

    function new();
      max_age     = MAX_AGE_RESET;
      error_count = 0;
      foreach (entry_live[i]) entry_live[i] = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction

    // Update the table for an accepted request and queue its verdict.
    function void note_request(logic func, logic [SRC_W-1:0] src,
                               logic [SEQ_W-1:0] seq, logic drop);
      logic [VERDICT_W-1:0] verdict;
      if (func == FUNC_TICK) begin
        // Every entry is visited once: expired ones are dropped, the rest age.
        foreach (entry_live[i]) begin
          if (entry_live[i]) begin
            if (entry_age[i] == '0) entry_live[i] = 1'b0;
            else entry_age[i] = entry_age[i] - AGE_W'(1);
          end
        end
        verdict = VERDICT_TICK;
      end else if (drop) begin
        verdict = VERDICT_UPSTREAM;
      end else if (int'(src) >= SOURCE_COUNT) begin
        verdict = VERDICT_STALE;
      end else if (entry_live[src] && (entry_seq[src] >= seq || entry_age[src] == '0)) begin
        verdict = VERDICT_STALE;
      end else begin
        entry_seq[src]  = seq;
        entry_age[src]  = max_age;
        entry_live[src] = 1'b1;
        verdict         = VERDICT_ACCEPT;
      end
      expected_verdicts.push_back(verdict);
    endfunction

    // Compare a delivered verdict with the oldest prediction.
    function void check_verdict(logic [VERDICT_W-1:0] actual);
      logic [VERDICT_W-1:0] want;
      if (expected_verdicts.size() == 0) begin
        error_count++;
        $error("verdict %0d delivered with no request outstanding", actual);
        return;
      end
      want = expected_verdicts.pop_front();
      if (actual !== want) begin
        error_count++;
        $error("verdict mismatch: expected %0d, actual %0d", want, actual);
      end
    endfunction
  endclass

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [AGE_W-1:0]     cfg_max_age_i   = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic                 func_i          = FUNC_PACKET;
  logic [SRC_W-1:0]     source_id_i     = '0;
  logic [SEQ_W-1:0]     seq_num_i       = '0;
  logic                 upstream_drop_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic [VERDICT_W-1:0] verdict_o;

  dup_filter_scoreboard sb = new();

  int unsigned      send_idle_pct = 11;
  int unsigned      recv_idle_pct = 76;
  int unsigned      cycle_count   = 0;
  logic [SRC_W-1:0] hot_src[HOT_COUNT];
  logic [SEQ_W-1:0] last_sent[SOURCE_COUNT];

  aging_duplicate_packet_filter_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_max_age_i   (cfg_max_age_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .source_id_i     (source_id_i),
    .seq_num_i       (seq_num_i),
    .upstream_drop_i (upstream_drop_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .verdict_o       (verdict_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side backpressure.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each verdict taken from the core.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_verdict(verdict_o);
  end

  // Give up on a hung core.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one request, wait for it to be taken, then maybe pause.
  task automatic issue(input logic func, input logic [SRC_W-1:0] src,
                       input logic [SEQ_W-1:0] seq, input logic drop);
    in_valid_i      <= 1'b1;
    func_i          <= func;
    source_id_i     <= src;
    seq_num_i       <= seq;
    upstream_drop_i <= drop;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(func, src, seq, drop);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Let all outstanding verdicts drain, then write max_age.
  task automatic reconfigure(input logic [AGE_W-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i   <= 1'b1;
    cfg_max_age_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.max_age = value;
    cfg_valid_i <= 1'b0;
  endtask

  // One random request: mostly rising numbers on busy sources, some noise.
  task automatic random_item();
    int unsigned      roll;
    logic [SRC_W-1:0] src;
    logic [SEQ_W-1:0] seq;
    roll = $urandom_range(99);
    if (roll < 7) begin
      issue(FUNC_TICK, SRC_W'($urandom), $urandom, 1'($urandom));
    end else begin
      src  = (roll < 20) ? SRC_W'($urandom) : hot_src[$urandom_range(HOT_COUNT - 1)];
      roll = $urandom_range(99);
      if (roll < 65) seq = last_sent[src] + $urandom_range(1, 4);
      else if (roll < 82) seq = last_sent[src] - $urandom_range(0, 2);
      else if (roll < 94) seq = $urandom;
      else seq = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      last_sent[src] = seq;
      issue(FUNC_PACKET, src, seq, ($urandom_range(99) < 8));
    end
  endtask

  // Main sequence.
  initial begin
    logic [AGE_W-1:0] age_plan[SEG_COUNT];
    foreach (last_sent[i]) last_sent[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of max_age: accept, equal and lower numbers, upstream drop,
    // both ends of the source and sequence ranges, and a tick with junk fields.
    issue(FUNC_PACKET, 8'd0, 32'd5, 1'b0);
    issue(FUNC_PACKET, 8'd0, 32'd5, 1'b0);
    issue(FUNC_PACKET, 8'd0, 32'd4, 1'b0);
    issue(FUNC_PACKET, 8'd0, 32'd6, 1'b1);
    issue(FUNC_PACKET, 8'd0, 32'd6, 1'b0);
    issue(FUNC_PACKET, 8'd255, 32'hFFFF_FFFF, 1'b0);
    issue(FUNC_PACKET, 8'd255, 32'd0, 1'b0);
    issue(FUNC_PACKET, 8'd1, 32'd0, 1'b0);
    issue(FUNC_PACKET, 8'd1, 32'd0, 1'b1);
    issue(FUNC_TICK, 8'hAA, 32'h5555_5555, 1'b1);

    // Zero max_age locks a source out until a tick expires its entry.
    reconfigure(16'd0);
    issue(FUNC_PACKET, 8'd2, 32'd100, 1'b0);
    issue(FUNC_PACKET, 8'd2, 32'd200, 1'b0);
    issue(FUNC_TICK, 8'd2, 32'd0, 1'b0);
    issue(FUNC_PACKET, 8'd2, 32'd50, 1'b0);

    // An entry with age one counts down, locks, then expires.
    reconfigure(16'd1);
    issue(FUNC_PACKET, 8'd3, 32'd1, 1'b0);
    issue(FUNC_TICK, 8'h55, 32'hAAAA_AAAA, 1'b0);
    issue(FUNC_PACKET, 8'd3, 32'd2, 1'b0);
    issue(FUNC_TICK, 8'd0, 32'd0, 1'b0);
    issue(FUNC_PACKET, 8'd3, 32'd2, 1'b0);
    issue(FUNC_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1);

    // Random traffic in segments, each with its own max_age, and an idling mix per pair of segments.
    age_plan = '{16'hFFFF, 16'd0, 16'd1, 16'd3, 16'($urandom_range(2, 20)), MAX_AGE_RESET};
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      reconfigure(age_plan[seg]);
      if (seg / 2 == 0) begin
        send_idle_pct = 11;
        recv_idle_pct = 76;
      end else if (seg / 2 == 1) begin
        send_idle_pct = 76;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      foreach (hot_src[i]) hot_src[i] = SRC_W'($urandom);
      repeat (SEG_ITEMS) random_item();
    end

    // Drain and let any late verdicts show up before the final word.
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
